// ===== src/ggfc_pkg.sv =====
`default_nettype none

package ggfc_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned BlockIdxW  = 10;
  localparam int unsigned ColorOutW  = 4;

  // Slave tdata: block_index, observed, neighbor_index, padded to whole bytes.
  localparam int unsigned SDataBits  = BlockIdxW + 1 + BlockIdxW;
  localparam int unsigned STdataW    = ((SDataBits + 7) / 8) * 8;

  // Master tdata: colored_block, has_color, color, overflow.
  localparam int unsigned MDataBits  = BlockIdxW + 1 + ColorOutW + 1;
  localparam int unsigned MTdataW    = ((MDataBits + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== src/greedy_first_fit_coloring.sv =====
`default_nettype none
// A deciding word (tlast high) passes stage 1 (the RAM read) and the result register on its way
// out, waiting in stage 1 while that register is full; words without tlast produce no output.
// Throughput: one word per cycle unless stalled; the color RAM has one read and one write port.
// Reset: asynchronous, active low. After reset the color RAM is swept to uncolored, one entry
// per cycle, over all BLOCKS entries; s_axis_tready_o stays low during that sweep.
module greedy_first_fit_coloring
  import ggfc_pkg::*;
#(
  parameter int unsigned BLOCKS = 1024,
  parameter int unsigned COLORS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output      logic               s_axis_tready_o,
  // [9:0] block_index, [10] observed, [20:11] neighbor_index, [23:21] zero
  input  wire logic [STdataW-1:0] s_axis_tdata_i,
  // [0] neighbor_valid
  input  wire logic               s_axis_tuser_i,
  input  wire logic               s_axis_tlast_i,
  output      logic               m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [9:0] colored_block, [10] has_color, [14:11] color, [15] overflow
  output      logic [MTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW  = $clog2(BLOCKS);
  localparam int unsigned ColorW = (COLORS > 2) ? $clog2(COLORS) : 1;
  localparam int unsigned EntryW = ColorW + 1;   // {valid, color}

  // Unpacked input fields.
  logic [BlockIdxW-1:0] in_blk;
  logic                 in_obs;
  logic [BlockIdxW-1:0] in_nb;
  logic [31:0]          in_nb_ext;
  logic [31:0]          s1_blk_ext;

  assign in_blk    = s_axis_tdata_i[BlockIdxW-1:0];
  assign in_obs    = s_axis_tdata_i[BlockIdxW];
  assign in_nb     = s_axis_tdata_i[2*BlockIdxW:BlockIdxW+1];
  assign in_nb_ext = 32'(in_nb);

  // Clearing sweep after reset.
  logic             clearing_q;
  logic [AddrW-1:0] clr_cnt_q;

  // Stage 1: the word whose RAM read is in flight.
  logic                 s1_valid_q;
  logic [BlockIdxW-1:0] s1_blk_q;
  logic                 s1_obs_q;
  logic                 s1_nb_ok_q;   // carries a neighbor that lies inside the RAM
  logic                 s1_last_q;
  logic                 byp_hit_q;
  logic [EntryW-1:0]    byp_data_q;
  logic [EntryW-1:0]    rd_data_q;

  logic [COLORS-1:0]    mask_q;
  logic [COLORS-1:0]    mask_d;

  logic                 m_valid_q;
  logic [MTdataW-1:0]   m_data_q;

  // Handshake and stage movement. Words without tlast never need the output register.
  logic s_accept;
  logic out_free;
  logic s1_adv;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Decision logic for the word in stage 1.
  logic [EntryW-1:0] nb_entry;
  logic [COLORS-1:0] contrib;
  logic [COLORS-1:0] used;
  logic [COLORS-1:0] free_set;
  logic [ColorW-1:0] pick;
  logic              got;
  logic              ovf;

  // A write landing in the same cycle as the read is taken from the bypass copy.
  assign nb_entry = byp_hit_q ? byp_data_q : rd_data_q;

  always_comb begin
    contrib = '0;
    if (s1_nb_ok_q && nb_entry[ColorW]) begin
      contrib[nb_entry[ColorW-1:0]] = 1'b1;
    end
  end

  assign used     = mask_q | contrib;
  assign free_set = ~used;

  // Lowest free color; scanning down leaves the lowest set bit.
  always_comb begin
    pick = '0;
    for (int i = COLORS - 1; i >= 0; i--) begin
      if (free_set[i]) begin
        pick = ColorW'(i);
      end
    end
  end

  assign ovf = s1_obs_q && (free_set == '0);
  assign got = s1_obs_q && (free_set != '0);

  assign mask_d = s1_last_q ? '0 : used;

  // RAM write port: the sweep, or a decision for an in-range block.
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [EntryW-1:0] wr_data;
  logic              s1_blk_ok;

  assign s1_blk_ext = 32'(s1_blk_q);
  assign s1_blk_ok  = s1_blk_ext < 32'(BLOCKS);
  assign wr_en      = clearing_q || (s1_adv && s1_last_q && s1_blk_ok);
  assign wr_addr    = clearing_q ? clr_cnt_q : s1_blk_ext[AddrW-1:0];
  assign wr_data    = (clearing_q || !got) ? '0 : {1'b1, pick};

  logic [AddrW-1:0] rd_addr;
  logic             in_nb_ok;

  assign rd_addr  = in_nb_ext[AddrW-1:0];
  assign in_nb_ok = s_axis_tuser_i && (in_nb_ext < 32'(BLOCKS));

  // Color RAM: one write and one registered read per cycle.
  logic [EntryW-1:0] color_mem_q [BLOCKS];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      color_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_data_q  <= color_mem_q[rd_addr];
      byp_hit_q  <= wr_en && (wr_addr == rd_addr);
      byp_data_q <= wr_data;
      s1_blk_q   <= in_blk;
      s1_obs_q   <= in_obs;
      s1_nb_ok_q <= in_nb_ok;
      s1_last_q  <= s_axis_tlast_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      mask_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(BLOCKS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (s_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        mask_q <= mask_d;
      end
      if (s1_adv && s1_last_q) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      m_data_q <= MTdataW'({ovf, (got ? ColorOutW'(pick) : ColorOutW'(0)), got, s1_blk_q});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire
